// File: rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// Switch loop detector package
// Shared constants, codes and the command and status types of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

   localparam int NUM_PORTS = 16;
   localparam int NP = (NUM_PORTS > 16) ? 16 : NUM_PORTS;

   localparam int MASK_W = 16;
   localparam int PORT_W = 4;
   localparam int COUNT_W = 4;
   localparam int AGE_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [MASK_W-1:0] PORT_ALL = MASK_W'((64'd1 << NP) - 64'd1);
   localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(NP - 1);

   localparam logic [AGE_W-1:0] AGE_RESET = 8'd10;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 4'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_AGE_SECONDS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MOVE_LIMIT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCK_ENABLE = 2'd2;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] LOOP_IDLE = 2'd0;
   localparam logic [1:0] LOOP_MONITORING = 2'd1;
   localparam logic [1:0] LOOP_LOOPING = 2'd2;

   typedef struct packed {
      logic load;
      logic advance;
   } slp_cmd_type;

   typedef struct packed {
      logic last;
   } slp_stat_type;

endpackage

`default_nettype wire

// File: rtl/slp_channels.sv
// ----------------------------------------------------------------------------
// Switch loop detector channels
// Valid/ready channels for the request beats and the response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface slp_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [15:0] mac_moved;
   logic [15:0] link_up;
   logic [15:0] self_seen_mask;

   modport source (output valid, output op, output mac_moved, output link_up,
                   output self_seen_mask, input ready);
   modport sink (input valid, input op, input mac_moved, input link_up,
                 input self_seen_mask, output ready);
endinterface

interface slp_rsp_if;
   logic valid;
   logic ready;
   logic entry_valid;
   logic [3:0] port_index;
   logic [15:0] forward_mask;
   logic last;
   logic [15:0] blocked_ports;
   logic [15:0] port_led_blink;
   logic system_led_blink;
   logic [1:0] loop_state;

   modport source (output valid, output entry_valid, output port_index,
                   output forward_mask, output last, output blocked_ports,
                   output port_led_blink, output system_led_blink,
                   output loop_state, input ready);
   modport sink (input valid, input entry_valid, input port_index,
                 input forward_mask, input last, input blocked_ports,
                 input port_led_blink, input system_led_blink,
                 input loop_state, output ready);
endinterface

`default_nettype wire

// File: rtl/slp_ctrl.sv
// ----------------------------------------------------------------------------
// Switch loop detector controller
// Takes one request beat at a time and steps the datapath through its
// response beats.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire slp_pkg::slp_stat_type stat,
   output slp_pkg::slp_cmd_type      cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      cmd.load = req_ready && req_valid;
      cmd.advance = rsp_valid && rsp_ready && !stat.last;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && stat.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/slp_datapath.sv
// ----------------------------------------------------------------------------
// Switch loop detector datapath
// Holds the configuration and detector state, updates it for each request
// and forms the response beats port by port.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [slp_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire logic [slp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire slp_pkg::slp_cmd_type                  cmd,
   output slp_pkg::slp_stat_type                      stat,
   input  wire logic                                  op,
   input  wire logic [slp_pkg::MASK_W-1:0]            mac_moved,
   input  wire logic [slp_pkg::MASK_W-1:0]            link_up,
   input  wire logic [slp_pkg::MASK_W-1:0]            self_seen_mask,
   output logic                                       entry_valid,
   output logic [slp_pkg::PORT_W-1:0]                 port_index,
   output logic [slp_pkg::MASK_W-1:0]                 forward_mask,
   output logic                                       last,
   output logic [slp_pkg::MASK_W-1:0]                 blocked_ports,
   output logic [slp_pkg::MASK_W-1:0]                 port_led_blink,
   output logic                                       system_led_blink,
   output logic [1:0]                                 loop_state
);

   logic [slp_pkg::AGE_W-1:0]   age_ff;
   logic [slp_pkg::COUNT_W-1:0] limit_ff;
   logic                        block_en_ff;

   logic [slp_pkg::COUNT_W-1:0] cnt_ff [slp_pkg::NP];
   logic [slp_pkg::COUNT_W-1:0] cnt_in [slp_pkg::NP];
   logic                        wo_ff, wo_in;
   logic [slp_pkg::AGE_W-1:0]   wl_ff, wl_in;
   logic [slp_pkg::MASK_W-1:0]  nbm_ff, nbm_in;
   logic [slp_pkg::MASK_W-1:0]  rbm_ff, rbm_in;
   logic [slp_pkg::MASK_W-1:0]  slm_ff, slm_in;
   logic                        leds_ff, leds_in;
   logic [slp_pkg::MASK_W-1:0]  pls_ff, pls_in;
   logic                        sys_ff, sys_in;
   logic [1:0]                  ds_ff, ds_in;

   logic                        tick_ff;
   logic [slp_pkg::MASK_W-1:0]  link_ff;
   logic [slp_pkg::PORT_W-1:0]  idx_ff, idx_in;

   logic [slp_pkg::MASK_W-1:0]  move;
   logic [slp_pkg::MASK_W-1:0]  link;
   logic [slp_pkg::AGE_W-1:0]   wl_dec;
   logic                        any_event;
   logic                        refresh;

   always_comb begin
      move = mac_moved & slp_pkg::PORT_ALL;
      link = link_up & slp_pkg::PORT_ALL;
      wl_dec = wl_ff - 8'd1;
      any_event = 1'b0;
      refresh = 1'b0;

      cnt_in = cnt_ff;
      wo_in = wo_ff;
      wl_in = wl_ff;
      nbm_in = nbm_ff;
      rbm_in = rbm_ff;
      slm_in = slm_ff;
      leds_in = leds_ff;
      pls_in = pls_ff;
      sys_in = sys_ff;
      ds_in = ds_ff;

      if (cmd.load && (op == slp_pkg::OP_TICK)) begin
         if (wo_ff) begin
            wl_in = wl_dec;
            if (wl_dec == '0) begin
               wo_in = 1'b0;
            end
         end
      end else if (cmd.load) begin
         // Ports with link down forget their counts and marks.
         slm_in = (slm_ff | (self_seen_mask & slp_pkg::PORT_ALL)) & link;
         nbm_in = nbm_ff & link;
         for (int p = 0; p < slp_pkg::NP; p++) begin
            if (!link[p]) begin
               cnt_in[p] = '0;
            end
         end

         any_event = (move | slm_in) != '0;
         if (any_event && !wo_ff && !leds_ff) begin
            wo_in = 1'b1;
            wl_in = age_ff;
            ds_in = slp_pkg::LOOP_MONITORING;
         end

         if (wo_in && any_event) begin
            for (int p = 0; p < slp_pkg::NP; p++) begin
               if (slm_in[p]) begin
                  nbm_in[p] = 1'b1;
                  cnt_in[p] = '0;
                  slm_in[p] = 1'b0;
                  ds_in = slp_pkg::LOOP_LOOPING;
               end else if (move[p]) begin
                  if (cnt_in[p] < limit_ff) begin
                     cnt_in[p] = cnt_in[p] + 4'd1;
                  end else begin
                     nbm_in[p] = 1'b1;
                     cnt_in[p] = '0;
                     ds_in = slp_pkg::LOOP_LOOPING;
                  end
               end
            end
         end

         if (nbm_in != rbm_ff) begin
            rbm_in = rbm_ff | nbm_in;
            refresh = 1'b1;
         end else if ((rbm_ff != '0) && !leds_ff) begin
            refresh = 1'b1;
         end
         if (refresh) begin
            rbm_in = rbm_in & link;
            pls_in = rbm_in;
            sys_in = 1'b1;
            leds_in = 1'b1;
         end

         if (!wo_in) begin
            if (leds_in) begin
               pls_in = '0;
               sys_in = 1'b0;
               leds_in = 1'b0;
               ds_in = slp_pkg::LOOP_IDLE;
            end
            for (int p = 0; p < slp_pkg::NP; p++) begin
               cnt_in[p] = '0;
            end
            nbm_in = '0;
            rbm_in = '0;
         end
      end
   end

   always_comb begin
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 4'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= slp_pkg::AGE_RESET;
         limit_ff <= slp_pkg::LIMIT_RESET;
         block_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            slp_pkg::CSR_AGE_SECONDS: begin
               age_ff <= csr_wdata;
            end
            slp_pkg::CSR_MOVE_LIMIT: begin
               limit_ff <= csr_wdata[slp_pkg::COUNT_W-1:0];
            end
            slp_pkg::CSR_BLOCK_ENABLE: begin
               block_en_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < slp_pkg::NP; p++) begin
            cnt_ff[p] <= '0;
         end
         wo_ff <= 1'b0;
         wl_ff <= slp_pkg::AGE_RESET;
         nbm_ff <= '0;
         rbm_ff <= '0;
         slm_ff <= '0;
         leds_ff <= 1'b0;
         pls_ff <= '0;
         sys_ff <= 1'b0;
         ds_ff <= slp_pkg::LOOP_IDLE;
         idx_ff <= '0;
         tick_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wo_ff <= wo_in;
         wl_ff <= wl_in;
         nbm_ff <= nbm_in;
         rbm_ff <= rbm_in;
         slm_ff <= slm_in;
         leds_ff <= leds_in;
         pls_ff <= pls_in;
         sys_ff <= sys_in;
         ds_ff <= ds_in;
         idx_ff <= idx_in;
         if (cmd.load) begin
            tick_ff <= op;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         link_ff <= link;
      end
   end

   always_comb begin
      entry_valid = !tick_ff;
      port_index = idx_ff;
      last = tick_ff || (idx_ff == slp_pkg::LAST_PORT);
      if (tick_ff) begin
         forward_mask = '0;
      end else begin
         forward_mask = link_ff & ~(16'd1 << idx_ff)
                        & ~(block_en_ff ? rbm_ff : 16'd0) & slp_pkg::PORT_ALL;
      end
      blocked_ports = rbm_ff;
      port_led_blink = pls_ff;
      system_led_blink = sys_ff;
      loop_state = ds_ff;
      stat.last = last;
   end

endmodule

`default_nettype wire

// File: rtl/switch_loop_detector.sv
// Timing: the first response beat to a request beat is valid in the cycle after it is taken.
// Flow: a tick gives a single response beat and a poll one per port, one forwarding mask per
// cycle while rsp_ready is high; no request is taken until the last response is accepted.
// Reset: synchronous, active high; clears the detector state and loads the register defaults.
// ----------------------------------------------------------------------------
// Switch loop detector
// Counts MAC moves per port, blocks looped ports and emits per-port
// source-forwarding masks together with the LED and loop status.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_loop_detector (
   input  wire logic                           clock,
   input  wire logic                           reset,
   slp_req_if.sink                             req_bus,
   slp_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [slp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [slp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   slp_pkg::slp_cmd_type  cmd;
   slp_pkg::slp_stat_type stat;
   logic                  req_ready;
   logic                  rsp_valid;

   slp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   slp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .op               (req_bus.op),
      .mac_moved        (req_bus.mac_moved),
      .link_up          (req_bus.link_up),
      .self_seen_mask   (req_bus.self_seen_mask),
      .entry_valid      (rsp_bus.entry_valid),
      .port_index       (rsp_bus.port_index),
      .forward_mask     (rsp_bus.forward_mask),
      .last             (rsp_bus.last),
      .blocked_ports    (rsp_bus.blocked_ports),
      .port_led_blink   (rsp_bus.port_led_blink),
      .system_led_blink (rsp_bus.system_led_blink),
      .loop_state       (rsp_bus.loop_state)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

`default_nettype wire
